// ----- sv/tfr_pkg.sv -----
// Shared types and constants of the transfer function resampler.
package tfr_pkg;

    localparam int CH_BITS   = 16;
    localparam int POS_BITS  = 17;
    localparam int ADDR_BITS = 6;
    localparam int DATA_BITS = 64;

    localparam logic [CH_BITS-1:0]  CH_MAX  = 16'hFFFF;
    localparam logic [POS_BITS-1:0] POS_ONE = 17'h10000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Input item kinds.
    localparam logic [1:0] KIND_LOAD_COLOR   = 2'd0;
    localparam logic [1:0] KIND_LOAD_OPACITY = 2'd1;
    localparam logic [1:0] KIND_QUERY        = 2'd2;

    // Color and opacity modes.
    localparam logic [1:0] CMODE_RGB    = 2'd1;
    localparam logic [1:0] CMODE_RGBA   = 2'd2;
    localparam logic       OMODE_POINTS = 1'b1;

    // Register indexes.
    localparam logic [2:0] REG_COLOR_MODE      = 3'd0;
    localparam logic [2:0] REG_COLOR_COUNT     = 3'd1;
    localparam logic [2:0] REG_UNIFORM_COLOR   = 3'd2;
    localparam logic [2:0] REG_OPACITY_MODE    = 3'd3;
    localparam logic [2:0] REG_OPACITY_COUNT   = 3'd4;
    localparam logic [2:0] REG_UNIFORM_OPACITY = 3'd5;

    typedef enum logic [1:0] {
        OP_LOAD_COLOR,
        OP_LOAD_OPACITY,
        OP_QUERY
    } tfr_op_t;

    typedef struct packed {
        tfr_op_t               op;
        logic [7:0]            slot;
        logic [63:0]           color;     // RGBA, red in the low bits
        logic [CH_BITS-1:0]    opacity;
        logic [POS_BITS-1:0]   position;  // already clamped to 1.0
    } tfr_item_t;

    typedef struct packed {
        logic [1:0]          color_mode;
        logic [8:0]          color_count;
        logic [63:0]         uniform_color;
        logic                opacity_mode;
        logic [8:0]          opacity_count;
        logic [CH_BITS-1:0]  uniform_opacity;
    } tfr_cfg_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } tfr_qstat_t;

endpackage

// ----- sv/tfr_regs.sv -----
// Configuration register file with its APB-style access port.
module tfr_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tfr_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [tfr_pkg::DATA_BITS-1:0]  pwdata,
    output logic [tfr_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output tfr_pkg::tfr_cfg_t              cfg
);
    import tfr_pkg::*;

    tfr_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_BITS-1:3];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_mode      <= '0;
            cfg_reg.color_count     <= '0;
            cfg_reg.uniform_color   <= '1;
            cfg_reg.opacity_mode    <= '0;
            cfg_reg.opacity_count   <= '0;
            cfg_reg.uniform_opacity <= CH_MAX;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_COLOR_MODE:      cfg_reg.color_mode      <= pwdata[1:0];
                REG_COLOR_COUNT:     cfg_reg.color_count     <= pwdata[8:0];
                REG_UNIFORM_COLOR:   cfg_reg.uniform_color   <= pwdata;
                REG_OPACITY_MODE:    cfg_reg.opacity_mode    <= pwdata[0];
                REG_OPACITY_COUNT:   cfg_reg.opacity_count   <= pwdata[8:0];
                REG_UNIFORM_OPACITY: cfg_reg.uniform_opacity <= pwdata[CH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COLOR_MODE:      prdata = DATA_BITS'(cfg_reg.color_mode);
            REG_COLOR_COUNT:     prdata = DATA_BITS'(cfg_reg.color_count);
            REG_UNIFORM_COLOR:   prdata = cfg_reg.uniform_color;
            REG_OPACITY_MODE:    prdata = DATA_BITS'(cfg_reg.opacity_mode);
            REG_OPACITY_COUNT:   prdata = DATA_BITS'(cfg_reg.opacity_count);
            REG_UNIFORM_OPACITY: prdata = DATA_BITS'(cfg_reg.uniform_opacity);
            default:             prdata = '0;
        endcase
    end

endmodule

// ----- sv/tfr_front.sv -----
// Input stage: accepts items, decodes their kind and drops those without effect.
module tfr_front #(
    parameter int MAX_POINTS = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [1:0]                       kind,
    input  logic [7:0]                       point_index,
    input  logic [tfr_pkg::CH_BITS-1:0]      red_in,
    input  logic [tfr_pkg::CH_BITS-1:0]      green_in,
    input  logic [tfr_pkg::CH_BITS-1:0]      blue_in,
    input  logic [tfr_pkg::CH_BITS-1:0]      alpha_in,
    input  logic [tfr_pkg::CH_BITS-1:0]      opacity_in,
    input  logic [tfr_pkg::POS_BITS-1:0]     position,
    input  tfr_pkg::tfr_qstat_t              qstat,
    output logic                             push,
    output tfr_pkg::tfr_item_t               push_item
);
    import tfr_pkg::*;

    logic      f_valid_reg, f_valid_next;
    tfr_item_t f_item_reg, f_item_next;
    tfr_item_t item_d;
    logic      keep;
    logic      slot_ok;
    logic      accept;

    assign push       = f_valid_reg && !qstat.full;
    assign item_stall = f_valid_reg && qstat.full;
    assign accept     = item_valid && !item_stall;
    assign push_item  = f_item_reg;
    assign slot_ok    = 32'(point_index) < MAX_POINTS;

    always_comb
    begin
        item_d.slot     = point_index;
        item_d.color    = {alpha_in, blue_in, green_in, red_in};
        item_d.opacity  = opacity_in;
        item_d.position = (position > POS_ONE) ? POS_ONE : position;
        unique case (kind)
            KIND_LOAD_COLOR:
            begin
                item_d.op = OP_LOAD_COLOR;
                keep      = slot_ok;
            end
            KIND_LOAD_OPACITY:
            begin
                item_d.op = OP_LOAD_OPACITY;
                keep      = slot_ok;
            end
            KIND_QUERY:
            begin
                item_d.op = OP_QUERY;
                keep      = 1'b1;
            end
            default:
            begin
                item_d.op = OP_QUERY;
                keep      = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        f_valid_next = f_valid_reg;
        f_item_next  = f_item_reg;
        if (accept)
        begin
            f_valid_next = keep;
            f_item_next  = item_d;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_item_reg <= f_item_next;
    end

endmodule

// ----- sv/tfr_queue.sv -----
// Short queue of decoded items between the input stage and the datapath.
module tfr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tfr_pkg::tfr_item_t    push_item,
    input  logic                  pop,
    output tfr_pkg::tfr_item_t    head,
    output tfr_pkg::tfr_qstat_t   qstat
);
    import tfr_pkg::*;

    tfr_item_t             slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  full;

    assign full           = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign qstat.full     = full;
    assign qstat.nonempty = count_reg != '0;
    assign head           = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue read while empty");
    a_count_tracks_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + QUEUE_CW'(1))
        else $error("queue count lost a transfer");
`endif

endmodule

// ----- sv/tfr_back.sv -----
// Datapath: point memories, segment search, interpolation and alpha product.
module tfr_back #(
    parameter int MAX_POINTS = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tfr_pkg::tfr_cfg_t              cfg,
    input  tfr_pkg::tfr_item_t             head,
    input  tfr_pkg::tfr_qstat_t            qstat,
    output logic                           pop,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [tfr_pkg::CH_BITS-1:0]    out_red,
    output logic [tfr_pkg::CH_BITS-1:0]    out_green,
    output logic [tfr_pkg::CH_BITS-1:0]    out_blue,
    output logic [tfr_pkg::CH_BITS-1:0]    out_alpha
);
    import tfr_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int IW = POS_BITS + NW;

    typedef struct packed {
        logic [AW-1:0]       i0;
        logic [POS_BITS-1:0] f;
    } seg_t;

    function automatic logic [NW-1:0] sat_n(input logic [8:0] cnt);
        logic [NW-1:0] n;
        if (32'(cnt) > MAX_POINTS)
        begin
            n = NW'(MAX_POINTS);
        end
        else
        begin
            n = NW'(cnt);
        end
        return n;
    endfunction

    // Segment start and fraction; fewer than two points use segment zero.
    function automatic seg_t locate(input logic [IW-1:0] idx, input logic [NW-1:0] n);
        logic [NW:0] lo;
        logic [NW:0] lim;
        seg_t        s;
        lo   = idx[IW-1:16];
        lim  = (NW+1)'(n) - (NW+1)'(2);
        s.i0 = '0;
        s.f  = '0;
        if (n >= NW'(2))
        begin
            if (lo > lim)
            begin
                s.i0 = AW'(lim);
                s.f  = POS_BITS'(idx - (IW'(lim) << 16));
            end
            else
            begin
                s.i0 = AW'(lo);
                s.f  = {1'b0, idx[15:0]};
            end
        end
        return s;
    endfunction

    function automatic logic [CH_BITS-1:0] mix_ch(input logic [CH_BITS-1:0] a,
                                                  input logic [CH_BITS-1:0] b,
                                                  input logic [POS_BITS-1:0] f);
        logic [32:0] pa;
        logic [32:0] pb;
        logic [33:0] v;
        pa = 33'(a) * 33'(POS_ONE - f);
        pb = 33'(b) * 33'(f);
        v  = 34'(pa) + 34'(pb) + 34'd32768;
        return v[31:16];
    endfunction

    logic [63:0]        color_mem [MAX_POINTS];
    logic [CH_BITS-1:0] opac_mem  [MAX_POINTS];

    logic          en;
    logic [NW-1:0] nc, no_n, nc_m1, no_m1;
    logic          color_pts;

    // Stage A: segment products.
    logic          a_valid_reg;
    tfr_item_t     a_item_reg;
    logic [IW-1:0] a_idx_c_reg, a_idx_c_next;
    logic [IW-1:0] a_idx_o_reg, a_idx_o_next;
    seg_t          seg_c, seg_o;

    // Stage B: point reads.
    logic                b_valid_reg;
    logic [POS_BITS-1:0] b_fc_reg, b_fo_reg;
    logic [63:0]         b_c0_reg, b_c1_reg;
    logic [CH_BITS-1:0]  b_o0_reg, b_o1_reg;

    // Stage C: interpolated color and opacity.
    logic                      c_valid_reg;
    logic [3:0][CH_BITS-1:0]   c_rgba_reg, c_rgba_next;
    logic [CH_BITS-1:0]        c_op_reg, c_op_next;

    // Stage D: alpha times opacity, before the divide by full scale.
    logic                      d_valid_reg;
    logic [2:0][CH_BITS-1:0]   d_rgb_reg;
    logic [31:0]               d_prod_reg, d_prod_next;

    // Output register.
    logic                 o_valid_reg;
    logic [CH_BITS-1:0]   o_red_reg, o_green_reg, o_blue_reg, o_alpha_reg;
    logic [CH_BITS-1:0]   alpha_next;
    logic [CH_BITS-1:0]   q0;
    logic [CH_BITS:0]     rem;

    // The whole pipeline moves together; the queue absorbs a stalled output.
    assign en  = !o_valid_reg || !result_stall;
    assign pop = en && qstat.nonempty;

    assign nc    = sat_n(cfg.color_count);
    assign no_n  = sat_n(cfg.opacity_count);
    assign nc_m1 = (nc != '0) ? nc - NW'(1) : '0;
    assign no_m1 = (no_n != '0) ? no_n - NW'(1) : '0;
    assign color_pts = (cfg.color_mode == CMODE_RGB) || (cfg.color_mode == CMODE_RGBA);

    assign a_idx_c_next = IW'(head.position) * IW'(nc_m1);
    assign a_idx_o_next = IW'(head.position) * IW'(no_m1);
    assign seg_c = locate(a_idx_c_reg, nc);
    assign seg_o = locate(a_idx_o_reg, no_n);

    // Loads write at the same stage where queries read, so a query sees every
    // load that was transferred before it.
    always_ff @(posedge clk)
    begin
        if (en && a_valid_reg && (a_item_reg.op == OP_LOAD_COLOR))
        begin
            color_mem[AW'(a_item_reg.slot)] <= a_item_reg.color;
        end
        if (en && a_valid_reg && (a_item_reg.op == OP_LOAD_OPACITY))
        begin
            opac_mem[AW'(a_item_reg.slot)] <= a_item_reg.opacity;
        end
        if (en)
        begin
            b_c0_reg <= color_mem[seg_c.i0];
            b_c1_reg <= color_mem[seg_c.i0 + AW'(1)];
            b_o0_reg <= opac_mem[seg_o.i0];
            b_o1_reg <= opac_mem[seg_o.i0 + AW'(1)];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (!color_pts)
            begin
                c_rgba_next[k] = cfg.uniform_color[16*k +: 16];
            end
            else if (nc == '0)
            begin
                c_rgba_next[k] = CH_MAX;
            end
            else if (nc == NW'(1))
            begin
                c_rgba_next[k] = b_c0_reg[16*k +: 16];
            end
            else
            begin
                c_rgba_next[k] = mix_ch(b_c0_reg[16*k +: 16], b_c1_reg[16*k +: 16], b_fc_reg);
            end
        end
        if (cfg.color_mode == CMODE_RGB)
        begin
            c_rgba_next[3] = CH_MAX;
        end

        if (cfg.opacity_mode != OMODE_POINTS)
        begin
            c_op_next = cfg.uniform_opacity;
        end
        else if (no_n == '0)
        begin
            c_op_next = '0;
        end
        else if (no_n == NW'(1))
        begin
            c_op_next = b_o0_reg;
        end
        else
        begin
            c_op_next = mix_ch(b_o0_reg, b_o1_reg, b_fo_reg);
        end
    end

    assign d_prod_next = 32'(c_rgba_reg[3]) * 32'(c_op_reg) + 32'd32767;

    // Divide by 65535: the quotient estimate is off by at most one.
    assign q0         = d_prod_reg[31:16];
    assign rem        = (CH_BITS+1)'(d_prod_reg[15:0]) + (CH_BITS+1)'(q0);
    assign alpha_next = (rem >= (CH_BITS+1)'(CH_MAX)) ? q0 + CH_BITS'(1) : q0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= qstat.nonempty;
            b_valid_reg <= a_valid_reg && (a_item_reg.op == OP_QUERY);
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            o_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg  <= head;
            a_idx_c_reg <= a_idx_c_next;
            a_idx_o_reg <= a_idx_o_next;
            b_fc_reg    <= seg_c.f;
            b_fo_reg    <= seg_o.f;
            c_rgba_reg  <= c_rgba_next;
            c_op_reg    <= c_op_next;
            d_rgb_reg   <= c_rgba_reg[2:0];
            d_prod_reg  <= d_prod_next;
            o_red_reg   <= d_rgb_reg[0];
            o_green_reg <= d_rgb_reg[1];
            o_blue_reg  <= d_rgb_reg[2];
            o_alpha_reg <= alpha_next;
        end
    end

    assign result_valid = o_valid_reg;
    assign out_red      = o_red_reg;
    assign out_green    = o_green_reg;
    assign out_blue     = o_blue_reg;
    assign out_alpha    = o_alpha_reg;

endmodule

// ----- sv/transfer_function_resampler.sv -----
// Top level of the transfer function resampler.
//
// Items arrive on the item channel (item_valid, item_stall). A kind of load
// color or load opacity writes one control point slot and gives no result; a
// query gives one RGBA result on the result channel (result_valid,
// result_stall), with alpha multiplied by the interpolated opacity.
// Results leave in the order of the queries.
// One item is taken per cycle while item_stall is low: the path is a fixed
// pipeline, and each point memory serves one write and two reads in every
// cycle. A load is visible to every query transferred after it.
// When the receiver stalls, the result is held and the pipeline freezes; a
// four-entry queue behind the input stage keeps taking items until it fills,
// and then item_stall rises.
// Reset empties the pipeline and the queue and sets the registers to their
// defaults; the point memories are not cleared and must be loaded before
// they are used. The user must write the registers over the APB-style port
// only while no item is in flight; the block itself does not enforce this.
module transfer_function_resampler #(
    parameter int MAX_POINTS = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tfr_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [tfr_pkg::DATA_BITS-1:0]  pwdata,
    output logic [tfr_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [1:0]                     kind,
    input  logic [7:0]                     point_index,
    input  logic [tfr_pkg::CH_BITS-1:0]    red_in,
    input  logic [tfr_pkg::CH_BITS-1:0]    green_in,
    input  logic [tfr_pkg::CH_BITS-1:0]    blue_in,
    input  logic [tfr_pkg::CH_BITS-1:0]    alpha_in,
    input  logic [tfr_pkg::CH_BITS-1:0]    opacity_in,
    input  logic [tfr_pkg::POS_BITS-1:0]   position,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [tfr_pkg::CH_BITS-1:0]    out_red,
    output logic [tfr_pkg::CH_BITS-1:0]    out_green,
    output logic [tfr_pkg::CH_BITS-1:0]    out_blue,
    output logic [tfr_pkg::CH_BITS-1:0]    out_alpha
);
    import tfr_pkg::*;

    tfr_cfg_t   cfg;
    tfr_qstat_t qstat;
    tfr_item_t  push_item;
    tfr_item_t  head;
    logic       push;
    logic       pop;

    tfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tfr_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .kind        (kind),
        .point_index (point_index),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .alpha_in    (alpha_in),
        .opacity_in  (opacity_in),
        .position    (position),
        .qstat       (qstat),
        .push        (push),
        .push_item   (push_item)
    );

    tfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    tfr_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha)
    );

endmodule
